[rtl/alru_pkg.sv]
// shared types and constants for the associative lookup table with lru replacement
package alru_pkg;

  localparam int unsigned KEY_W  = 64;
  localparam int unsigned SLOT_W = 4;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  typedef struct packed {
    logic key_we;
    logic age_we;
  } alru_we_t;

  typedef struct packed {
    logic key_eq;
    logic age_lt;
    logic age_zero;
  } alru_cmp_t;

endpackage

[rtl/assoc_lookup_lru_replace.sv]
// top level: sequencer, valid bits and result registers of the lru tag table
// a lookup miss runs only the scan pass, a lookup hit the scan and age passes, and an insert
// the scan pass, a write and the age pass; both passes step one entry per cycle over the
// single read port of the key and age memories
// one request at a time: busy stays high from accept until done_o pulses, and the next
// request can be taken at the edge that takes the result beat; the receiver cannot stall
// reset clears all valid bits at once, so the table is empty without a clear pass
module assoc_lookup_lru_replace #(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned KEY_BITS = 64,
  parameter int unsigned AGE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          req_type_i,
  input  logic [alru_pkg::KEY_W-1:0]    key_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic [alru_pkg::SLOT_W-1:0]   slot_o
);
  import alru_pkg::*;

  localparam int unsigned ADDR_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_BITS  = ADDR_BITS + 1;
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_AGE
  } state_e;

  state_e               state_q;
  logic [CNT_BITS-1:0]  idx_q;
  logic [ENTRIES-1:0]   valid_q;
  logic                 req_q;
  logic [KEY_BITS-1:0]  key_q;
  logic                 found_q;
  logic                 have_q;
  logic [ADDR_BITS-1:0] sel_q;
  logic [AGE_BITS-1:0]  best_q;
  logic                 done_q;
  logic                 hit_q;
  logic [SLOT_W-1:0]    slot_q;

  logic [ADDR_BITS-1:0] rd_addr;
  logic [ADDR_BITS-1:0] p_idx;
  logic                 p_vld;
  logic                 proc;
  logic                 last;
  logic                 scan_match;
  logic [KEY_BITS-1:0]  rd_key;
  logic [AGE_BITS-1:0]  rd_age;
  logic [AGE_BITS-1:0]  age_dec;
  alru_cmp_t            cmp;
  alru_we_t             we;
  logic [ADDR_BITS-1:0] wr_addr;
  logic [AGE_BITS-1:0]  wr_age;

  alru_mem #(
    .ENTRIES   (ENTRIES),
    .KEY_BITS  (KEY_BITS),
    .AGE_BITS  (AGE_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (we),
    .wr_addr_i (wr_addr),
    .wr_key_i  (key_q),
    .wr_age_i  (wr_age),
    .rd_addr_i (rd_addr),
    .rd_key_o  (rd_key),
    .rd_age_o  (rd_age)
  );

  alru_unit #(
    .KEY_BITS (KEY_BITS),
    .AGE_BITS (AGE_BITS)
  ) u_unit (
    .rd_key_i   (rd_key),
    .req_key_i  (key_q),
    .rd_age_i   (rd_age),
    .best_age_i (best_q),
    .cmp_o      (cmp),
    .age_dec_o  (age_dec)
  );

  // read data of entry idx-1 arrives while idx is issued
  always_comb begin
    rd_addr = idx_q[ADDR_BITS-1:0];
    p_idx   = ADDR_BITS'(idx_q - CNT_BITS'(1));
    p_vld   = valid_q[p_idx];
    proc    = (idx_q != '0);
    last    = (idx_q == CNT_BITS'(ENTRIES));
    if (req_q == REQ_LOOKUP) begin
      scan_match = proc && !found_q && p_vld && cmp.key_eq;
    end else begin
      scan_match = proc && !found_q && !p_vld;
    end
    we      = '0;
    wr_addr = sel_q;
    wr_age  = AGE_MAX;
    if (state_q == S_WRITE) begin
      we.key_we = 1'b1;
      we.age_we = 1'b1;
    end else if (state_q == S_AGE && proc && p_vld && p_idx != sel_q && !cmp.age_zero) begin
      we.age_we = 1'b1;
      wr_addr   = p_idx;
      wr_age    = age_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      valid_q <= '0;
      req_q   <= REQ_LOOKUP;
      key_q   <= '0;
      found_q <= 1'b0;
      have_q  <= 1'b0;
      sel_q   <= '0;
      best_q  <= '0;
      done_q  <= 1'b0;
      hit_q   <= 1'b0;
      slot_q  <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            req_q   <= req_type_i;
            key_q   <= key_i[KEY_BITS-1:0];
            idx_q   <= '0;
            found_q <= 1'b0;
            have_q  <= 1'b0;
            sel_q   <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          idx_q <= idx_q + CNT_BITS'(1);
          if (scan_match) begin
            found_q <= 1'b1;
            sel_q   <= p_idx;
          end else if (proc && !found_q && req_q == REQ_INSERT
                       && (!have_q || cmp.age_lt)) begin
            // full so far: track the oldest entry, first one wins ties
            best_q <= rd_age;
            sel_q  <= p_idx;
            have_q <= 1'b1;
          end
          if (last) begin
            idx_q <= '0;
            if (req_q == REQ_INSERT) begin
              state_q <= S_WRITE;
            end else if (found_q || scan_match) begin
              state_q <= S_AGE;
            end else begin
              done_q  <= 1'b1;
              hit_q   <= 1'b0;
              slot_q  <= '0;
              state_q <= S_IDLE;
            end
          end
        end
        S_WRITE: begin
          valid_q[sel_q] <= 1'b1;
          idx_q          <= '0;
          state_q        <= S_AGE;
        end
        S_AGE: begin
          idx_q <= idx_q + CNT_BITS'(1);
          if (last) begin
            idx_q   <= '0;
            done_q  <= 1'b1;
            hit_q   <= (req_q == REQ_LOOKUP);
            slot_q  <= SLOT_W'(sel_q);
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign hit_o  = hit_q;
  assign slot_o = slot_q;

  // a result beat only comes out once the sequencer is back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE)
    else $error("result beat while sequencer busy");

  // an insert always leaves its chosen slot valid
  a_insert_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && req_q == REQ_INSERT) |-> valid_q[sel_q])
    else $error("inserted slot not valid");

  // hit is only reported for a lookup
  a_hit_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && hit_q) |-> req_q == REQ_LOOKUP)
    else $error("hit reported for insert");

  // an accepted request starts the scan from entry zero
  a_start_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == S_SCAN && idx_q == '0))
    else $error("accepted request did not start scan");

  // a lookup hit slot must be a valid entry
  a_hit_slot_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AGE && req_q == REQ_LOOKUP) |-> valid_q[sel_q])
    else $error("lookup hit on invalid slot");

endmodule

[rtl/alru_mem.sv]
// key and age storage, one write port and one registered read port each
module alru_mem #(
  parameter int unsigned ENTRIES   = 16,
  parameter int unsigned KEY_BITS  = 64,
  parameter int unsigned AGE_BITS  = 32,
  parameter int unsigned ADDR_BITS = 4
) (
  input  logic                  clk_i,
  input  alru_pkg::alru_we_t    we_i,
  input  logic [ADDR_BITS-1:0]  wr_addr_i,
  input  logic [KEY_BITS-1:0]   wr_key_i,
  input  logic [AGE_BITS-1:0]   wr_age_i,
  input  logic [ADDR_BITS-1:0]  rd_addr_i,
  output logic [KEY_BITS-1:0]   rd_key_o,
  output logic [AGE_BITS-1:0]   rd_age_o
);
  import alru_pkg::*;

  logic [KEY_BITS-1:0] key_mem [ENTRIES];
  logic [AGE_BITS-1:0] age_mem [ENTRIES];
  logic [KEY_BITS-1:0] rd_key_q;
  logic [AGE_BITS-1:0] rd_age_q;

  always_ff @(posedge clk_i) begin
    if (we_i.key_we) begin
      key_mem[wr_addr_i] <= wr_key_i;
    end
    if (we_i.age_we) begin
      age_mem[wr_addr_i] <= wr_age_i;
    end
    rd_key_q <= key_mem[rd_addr_i];
    rd_age_q <= age_mem[rd_addr_i];
  end

  assign rd_key_o = rd_key_q;
  assign rd_age_o = rd_age_q;

endmodule

[rtl/alru_unit.sv]
// shared compare and decrement unit used by every step of the scan and age passes
module alru_unit #(
  parameter int unsigned KEY_BITS = 64,
  parameter int unsigned AGE_BITS = 32
) (
  input  logic [KEY_BITS-1:0]  rd_key_i,
  input  logic [KEY_BITS-1:0]  req_key_i,
  input  logic [AGE_BITS-1:0]  rd_age_i,
  input  logic [AGE_BITS-1:0]  best_age_i,
  output alru_pkg::alru_cmp_t  cmp_o,
  output logic [AGE_BITS-1:0]  age_dec_o
);
  import alru_pkg::*;

  always_comb begin
    cmp_o.key_eq   = (rd_key_i == req_key_i);
    cmp_o.age_lt   = (rd_age_i < best_age_i);
    cmp_o.age_zero = (rd_age_i == '0);
    age_dec_o      = rd_age_i - AGE_BITS'(1);
  end

endmodule
